// ===== hdl/fbb_pkg.sv =====
// Shared types and constants for the foreground bounding box block.
package fbb_pkg;

  localparam int MAX_DIM = 2048;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W   = 12;
  localparam int PIX_W   = 32;
  localparam int CNT_W   = 23;
  localparam int BOX_W   = 11;
  localparam int RES_W   = PIX_W + CNT_W + 4 * BOX_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } fbb_reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } fbb_cfg_t;

  // Packed so that background lands in the lowest bits.
  typedef struct packed {
    logic [BOX_W-1:0] box_max_y;
    logic [BOX_W-1:0] box_max_x;
    logic [BOX_W-1:0] box_min_y;
    logic [BOX_W-1:0] box_min_x;
    logic [CNT_W-1:0] foreground_count;
    logic [PIX_W-1:0] background;
  } fbb_result_t;

  // Last index for a dimension register: zero acts as 1, above MAX_DIM clamps.
  function automatic logic [COORD_W-1:0] last_index(input logic [DIM_W-1:0] dim);
    logic [COORD_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (32'(dim) > MAX_DIM) begin
      res = COORD_W'(MAX_DIM - 1);
    end else begin
      res = COORD_W'(dim - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

// ===== hdl/fbb_in_stage.sv =====
// Input register stage for the pixel stream.
module fbb_in_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [fbb_pkg::PIX_W-1:0] in_tdata,
  input  logic                     advance,
  output logic                     pix_valid,
  output logic [fbb_pkg::PIX_W-1:0] pix
);
  import fbb_pkg::*;

  logic             valid_r, valid_nxt;
  logic [PIX_W-1:0] pix_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r <= in_tdata;
    end
  end

  assign pix_valid = valid_r;
  assign pix       = pix_r;

endmodule

// ===== hdl/fbb_accum.sv =====
// Raster counters, background latch and running box/count accumulation.
module fbb_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fbb_pkg::fbb_cfg_t         cfg,
  input  logic                      step,
  input  logic [fbb_pkg::PIX_W-1:0] pix,
  output logic                      frame_end,
  output fbb_pkg::fbb_result_t      result
);
  import fbb_pkg::*;

  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [PIX_W-1:0]   bg_r, bg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COORD_W-1:0] minx_r, minx_nxt, miny_r, miny_nxt;
  logic [COORD_W-1:0] maxx_r, maxx_nxt, maxy_r, maxy_nxt;
  logic [COORD_W-1:0] last_col, last_row;
  logic               first, fg, row_end, any;

  assign last_col = last_index(cfg.frame_width);
  assign last_row = last_index(cfg.frame_height);

  always_comb begin
    first    = (x_r == '0) && (y_r == '0);
    fg       = !first && (pix != bg_r);
    bg_nxt   = bg_r;
    cnt_nxt  = cnt_r;
    minx_nxt = minx_r;
    miny_nxt = miny_r;
    maxx_nxt = maxx_r;
    maxy_nxt = maxy_r;
    if (first) begin
      bg_nxt   = pix;
      cnt_nxt  = '0;
      minx_nxt = '0;
      miny_nxt = '0;
      maxx_nxt = '0;
      maxy_nxt = '0;
    end else if (fg) begin
      if (cnt_r == '0) begin
        // first foreground pixel seeds the box
        minx_nxt = x_r;
        miny_nxt = y_r;
        maxx_nxt = x_r;
        maxy_nxt = y_r;
      end else begin
        if (x_r < minx_r) minx_nxt = x_r;
        if (y_r < miny_r) miny_nxt = y_r;
        if (x_r > maxx_r) maxx_nxt = x_r;
        if (y_r > maxy_r) maxy_nxt = y_r;
      end
      if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end

    // >= so a shrunk dimension mid-frame wraps on the next pixel
    row_end   = (x_r >= last_col);
    frame_end = row_end && (y_r >= last_row);
    if (frame_end) begin
      x_nxt = '0;
      y_nxt = '0;
    end else if (row_end) begin
      x_nxt = '0;
      y_nxt = y_r + COORD_W'(1);
    end else begin
      x_nxt = x_r + COORD_W'(1);
      y_nxt = y_r;
    end

    any = (cnt_nxt != '0);
    result.background       = bg_nxt;
    result.foreground_count = cnt_nxt;
    result.box_min_x        = any ? BOX_W'(minx_nxt) : '0;
    result.box_min_y        = any ? BOX_W'(miny_nxt) : '0;
    result.box_max_x        = any ? BOX_W'(maxx_nxt) : '0;
    result.box_max_y        = any ? BOX_W'(maxy_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      bg_r   <= '0;
      cnt_r  <= '0;
      minx_r <= '0;
      miny_r <= '0;
      maxx_r <= '0;
      maxy_r <= '0;
    end else if (step) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      bg_r   <= bg_nxt;
      cnt_r  <= cnt_nxt;
      minx_r <= minx_nxt;
      miny_r <= miny_nxt;
      maxx_r <= maxx_nxt;
      maxy_r <= maxy_nxt;
    end
  end

endmodule

// ===== hdl/fbb_out_stage.sv =====
// Result register driving the output stream.
module fbb_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  fbb_pkg::fbb_result_t           result,
  output logic                           slot_free,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fbb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fbb_pkg::*;

  logic        valid_r, valid_nxt;
  fbb_result_t data_r;

  assign slot_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), data_r};

endmodule

// ===== hdl/foreground_bounding_box.sv =====
// Top level: foreground pixel count and bounding box over raster frames.
// A frame's result word is loaded into the result register once its last pixel word leaves the input register.
// Throughput: one pixel word per cycle, sustained while the output side keeps up.
// The pixel path stalls only when a result word is waiting and out_tready is low.
// Reset (synchronous, rst_n low): counters, box and count cleared, frame
// width 800 and height 480, both stream stages empty.
module foreground_bounding_box (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [fbb_pkg::DIM_W-1:0]        cfg_wdata,
  // pixel stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fbb_pkg::PIX_W-1:0]        in_tdata,   // [31:0] pixel
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] background, [54:32] foreground_count, [65:55] box_min_x,
  // [76:66] box_min_y, [87:77] box_max_x, [98:88] box_max_y, rest zero
  output logic [fbb_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import fbb_pkg::*;

  fbb_cfg_t         cfg_r;
  logic             pix_valid, slot_free, step, frame_end;
  logic [PIX_W-1:0] pix;
  fbb_result_t      result;

  // config registers; index beyond the list cannot occur at 1 bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= DIM_W'(800);
      cfg_r.frame_height <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (fbb_reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pixel word moves on whenever the result slot can take a word
  assign step = pix_valid && slot_free;

  fbb_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (slot_free),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  fbb_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (step),
    .pix       (pix),
    .frame_end (frame_end),
    .result    (result)
  );

  fbb_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && frame_end),
    .result     (result),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
